// ===== sv/pdc_pkg.sv =====
// pdc_pkg: shared widths, status codes and structs of the pwm duty cycle capture block
// no dependencies; imported by pdc_regs, pdc_meas and pwm_duty_cycle_capture
package pdc_pkg;

	localparam int TPM_BITS  = 20;
	localparam int TMO_BITS  = 17;
	localparam int MS_BITS   = 16;
	localparam int CNT_BITS  = 16;
	localparam int SUM_BITS  = 32;
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	localparam logic [TPM_BITS-1:0] TPM_RESET = 20'd16000;
	localparam logic [TMO_BITS-1:0] TMO_RESET = 17'h10000;

	// register indexes, taken from paddr[2]
	localparam logic REG_TPM = 1'b0;
	localparam logic REG_TMO = 1'b1;

	// item kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	// status codes
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_BUSY   = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;
	localparam logic [1:0] ST_NOCONN = 2'd3;

	typedef struct packed {
		logic [TPM_BITS-1:0] ticks_per_ms;
		logic [TMO_BITS-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [CNT_BITS-1:0] cycle_count;
		logic [SUM_BITS-1:0] total_ticks;
		logic [SUM_BITS-1:0] high_ticks;
	} result_t;

endpackage

// ===== sv/pdc_regs.sv =====
// pdc_regs: apb-style configuration registers (ticks per ms, timeout)
// depends on pdc_pkg
module pdc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pdc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [pdc_pkg::DATA_BITS-1:0] pwdata,
	output logic [pdc_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	output pdc_pkg::cfg_t                 cfg
);
	import pdc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	// write strobe in the access phase
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_ms  <= TPM_RESET;
			cfg_q.timeout_ticks <= TMO_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_TPM: cfg_q.ticks_per_ms  <= pwdata[TPM_BITS-1:0];
				REG_TMO: cfg_q.timeout_ticks <= pwdata[TMO_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			REG_TPM: prdata = DATA_BITS'(cfg_q.ticks_per_ms);
			REG_TMO: prdata = DATA_BITS'(cfg_q.timeout_ticks);
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/pdc_meas.sv =====
// pdc_meas: measurement state and single-pass next-state logic for one beat
// depends on pdc_pkg
module pdc_meas #(
	parameter int STAMP_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        kind,
	input  logic                        pin_level,
	input  logic [pdc_pkg::MS_BITS-1:0] min_ms,
	input  pdc_pkg::cfg_t               cfg,
	output pdc_pkg::result_t            result
);
	import pdc_pkg::*;

	logic [STAMP_BITS-1:0] tick_counter_q, rise_stamp_q, fall_stamp_q;
	logic                  waiting_falling_q, last_level_q;
	logic [CNT_BITS-1:0]   edge_count_q;
	logic [SUM_BITS-1:0]   period_sum_q, high_sum_q, target_ticks_q;
	logic [TMO_BITS-1:0]   since_rise_q;
	logic [1:0]            run_status_q;

	logic [STAMP_BITS-1:0] tick_counter_n, rise_stamp_n, fall_stamp_n;
	logic                  waiting_falling_n;
	logic [CNT_BITS-1:0]   edge_count_n;
	logic [SUM_BITS-1:0]   period_sum_n, high_sum_n, target_ticks_n;
	logic [TMO_BITS-1:0]   since_rise_n, since_inc;
	logic [1:0]            run_status_n;

	logic [TPM_BITS+MS_BITS-1:0] target_prod;
	logic [STAMP_BITS-1:0]       high_d, period_d;
	logic [SUM_BITS:0]           high_add, period_add;
	logic [SUM_BITS-1:0]         high_sat, period_sat;
	logic                        rising, falling, got_rise, got_fall, done;

	// start target, saturated to the sum width
	assign target_prod = TPM_BITS'(cfg.ticks_per_ms) * (TPM_BITS+MS_BITS)'(min_ms);

	// edge detect and saturating sums for a falling edge
	assign rising     = !last_level_q && pin_level;
	assign falling    = last_level_q && !pin_level;
	assign high_d     = tick_counter_q - rise_stamp_q;
	assign period_d   = tick_counter_q - fall_stamp_q;
	assign high_add   = {1'b0, high_sum_q} + (SUM_BITS+1)'(high_d);
	assign period_add = {1'b0, period_sum_q} + (SUM_BITS+1)'(period_d);
	assign high_sat   = high_add[SUM_BITS] ? '1 : high_add[SUM_BITS-1:0];
	assign period_sat = period_add[SUM_BITS] ? '1 : period_add[SUM_BITS-1:0];
	assign since_inc  = (since_rise_q != '1) ? since_rise_q + 1'b1 : since_rise_q;

	// next state
	always_comb begin
		tick_counter_n    = tick_counter_q;
		rise_stamp_n      = rise_stamp_q;
		fall_stamp_n      = fall_stamp_q;
		waiting_falling_n = waiting_falling_q;
		edge_count_n      = edge_count_q;
		period_sum_n      = period_sum_q;
		high_sum_n        = high_sum_q;
		target_ticks_n    = target_ticks_q;
		since_rise_n      = since_rise_q;
		run_status_n      = run_status_q;
		got_rise          = 1'b0;
		got_fall          = 1'b0;
		done              = 1'b0;
		if (kind == KIND_START) begin
			target_ticks_n    = (|target_prod[TPM_BITS+MS_BITS-1:SUM_BITS]) ? '1
			                  : target_prod[SUM_BITS-1:0];
			tick_counter_n    = '0;
			since_rise_n      = '0;
			edge_count_n      = '0;
			period_sum_n      = '0;
			high_sum_n        = '0;
			waiting_falling_n = 1'b0;
			run_status_n      = ST_BUSY;
		end else begin
			tick_counter_n = tick_counter_q + 1'b1;
			if (run_status_q == ST_BUSY) begin
				got_rise = rising && !waiting_falling_q;
				got_fall = falling && waiting_falling_q;
				if (got_rise) begin
					rise_stamp_n      = tick_counter_q;
					waiting_falling_n = 1'b1;
				end else if (got_fall) begin
					waiting_falling_n = 1'b0;
					if (edge_count_q != '0) begin
						high_sum_n   = high_sat;
						period_sum_n = period_sat;
						done = (period_sat >= target_ticks_q) && (edge_count_q[2:0] == 3'd0);
					end
					if (!done) begin
						fall_stamp_n = tick_counter_q;
						edge_count_n = edge_count_q + 1'b1;
					end
				end
				// finish or timeout
				if (got_rise) begin
					since_rise_n = '0;
				end else if (done) begin
					run_status_n = ST_DONE;
				end else begin
					since_rise_n = since_inc;
					if (since_inc >= cfg.timeout_ticks) run_status_n = ST_NOCONN;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_counter_q    <= '0;
			rise_stamp_q      <= '0;
			fall_stamp_q      <= '0;
			waiting_falling_q <= 1'b0;
			last_level_q      <= 1'b0;
			edge_count_q      <= '0;
			period_sum_q      <= '0;
			high_sum_q        <= '0;
			target_ticks_q    <= '0;
			since_rise_q      <= '0;
			run_status_q      <= ST_IDLE;
		end else if (step) begin
			tick_counter_q    <= tick_counter_n;
			rise_stamp_q      <= rise_stamp_n;
			fall_stamp_q      <= fall_stamp_n;
			waiting_falling_q <= waiting_falling_n;
			if (kind == KIND_TICK) last_level_q <= pin_level;
			edge_count_q      <= edge_count_n;
			period_sum_q      <= period_sum_n;
			high_sum_q        <= high_sum_n;
			target_ticks_q    <= target_ticks_n;
			since_rise_q      <= since_rise_n;
			run_status_q      <= run_status_n;
		end
	end

	assign result.status      = run_status_n;
	assign result.cycle_count = edge_count_n;
	assign result.total_ticks = period_sum_n;
	assign result.high_ticks  = high_sum_n;

`ifndef SYNTHESIS
	// a start always leaves the block busy with cleared totals
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind == KIND_START |=> run_status_q == ST_BUSY && period_sum_q == '0
		&& high_sum_q == '0 && edge_count_q == '0)
		else $error("start did not clear the measurement");

	// totals hold outside a running measurement
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind == KIND_TICK && run_status_q != ST_BUSY
		|=> $stable(period_sum_q) && $stable(high_sum_q) && $stable(run_status_q))
		else $error("totals moved while not busy");

	// no state change without a beat
	a_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(tick_counter_q) && $stable(edge_count_q) && $stable(run_status_q))
		else $error("state moved without a beat");

	// edge count only steps by one or clears
	a_edge_step: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> edge_count_q == $past(edge_count_q) || edge_count_q == '0
		|| edge_count_q == $past(edge_count_q) + 1'b1)
		else $error("edge count jumped");
`endif

endmodule

// ===== sv/pwm_duty_cycle_capture.sv =====
// pwm duty cycle capture: turns input beats (pin samples and starts) into result beats
// throughput one beat per cycle while out_stall does not hold the result register, one result for every input beat
// input register, single-pass update of the measurement state, result register
// asynchronous active-low reset: idle, counters and totals zero, registers at defaults
// depends on pdc_pkg, pdc_regs, pdc_meas
module pwm_duty_cycle_capture #(
	parameter int STAMP_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pdc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [pdc_pkg::DATA_BITS-1:0] pwdata,
	output logic [pdc_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic                          pin_level,
	input  logic [pdc_pkg::MS_BITS-1:0]   min_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [pdc_pkg::CNT_BITS-1:0]  cycle_count,
	output logic [pdc_pkg::SUM_BITS-1:0]  total_ticks,
	output logic [pdc_pkg::SUM_BITS-1:0]  high_ticks
);
	import pdc_pkg::*;

	cfg_t    cfg;
	result_t result;
	result_t result_s2;

	logic               valid_s1, kind_s1, pin_level_s1;
	logic [MS_BITS-1:0] min_ms_s1;
	logic               out_valid_q, advance, step;

	pdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage 1 moves on when the result register is free
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1      <= kind;
			pin_level_s1 <= pin_level;
			min_ms_s1    <= min_ms;
		end
	end

	pdc_meas #(
		.STAMP_BITS (STAMP_BITS)
	) u_meas (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.kind      (kind_s1),
		.pin_level (pin_level_s1),
		.min_ms    (min_ms_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) result_s2 <= result;
	end

	assign out_valid   = out_valid_q;
	assign status      = result_s2.status;
	assign cycle_count = result_s2.cycle_count;
	assign total_ticks = result_s2.total_ticks;
	assign high_ticks  = result_s2.high_ticks;

endmodule

// ===== test/pdc_tb_pkg.sv =====
// pdc_tb_pkg: duty cycle scoreboard for the pwm duty cycle capture testbench
// predicts every result beat from the accepted input beats and checks the dut output
// depends on pdc_pkg
package pdc_tb_pkg;

	import pdc_pkg::*;

	class duty_scoreboard;
		// register copies
		logic [TPM_BITS-1:0] ticks_per_ms;
		logic [TMO_BITS-1:0] timeout_ticks;

		// measurement state
		logic [CNT_BITS-1:0] tick_cnt;
		logic [CNT_BITS-1:0] rise_stamp;
		logic [CNT_BITS-1:0] fall_stamp;
		logic [CNT_BITS-1:0] edge_cnt;
		logic                wait_fall;
		logic                last_lvl;
		logic [SUM_BITS-1:0] period_sum;
		logic [SUM_BITS-1:0] high_sum;
		logic [SUM_BITS-1:0] target;
		logic [TMO_BITS-1:0] since_rise;
		logic [1:0]          run_st;

		result_t expected_readings[$];
		int      errors;

		function new();
			ticks_per_ms  = TPM_RESET;
			timeout_ticks = TMO_RESET;
			tick_cnt      = '0;
			rise_stamp    = '0;
			fall_stamp    = '0;
			edge_cnt      = '0;
			wait_fall     = 1'b0;
			last_lvl      = 1'b0;
			period_sum    = '0;
			high_sum      = '0;
			target        = '0;
			since_rise    = '0;
			run_st        = ST_IDLE;
			errors        = 0;
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction

		// saturating 32-bit accumulate
		function logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] acc, logic [CNT_BITS-1:0] len);
			logic [SUM_BITS:0] s;
			s = acc + len;
			return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
		endfunction

		// advance the measurement by one accepted input beat
		function void note_sample(logic k, logic lvl, logic [MS_BITS-1:0] ms);
			logic [47:0]         prod;
			logic [CNT_BITS-1:0] stamp;
			logic [CNT_BITS-1:0] hi_len;
			logic [CNT_BITS-1:0] per_len;
			logic                rising;
			logic                falling;
			logic                done;
			if (k == KIND_START) begin
				prod       = ms * ticks_per_ms;
				target     = (prod > 48'hFFFF_FFFF) ? '1 : prod[SUM_BITS-1:0];
				tick_cnt   = '0;
				since_rise = '0;
				edge_cnt   = '0;
				period_sum = '0;
				high_sum   = '0;
				wait_fall  = 1'b0;
				run_st     = ST_BUSY;
			end else begin
				stamp    = tick_cnt;
				rising   = !last_lvl && lvl;
				falling  = last_lvl && !lvl;
				tick_cnt = tick_cnt + 1'b1;
				last_lvl = lvl;
				if (run_st == ST_BUSY) begin
					done = 1'b0;
					if (rising && !wait_fall) begin
						rise_stamp = stamp;
						wait_fall  = 1'b1;
						since_rise = '0;
					end else begin
						// falling edge closes a cycle from the second one on
						if (falling && wait_fall) begin
							wait_fall = 1'b0;
							if (edge_cnt != '0) begin
								hi_len     = stamp - rise_stamp;
								per_len    = stamp - fall_stamp;
								high_sum   = sat_add(high_sum, hi_len);
								period_sum = sat_add(period_sum, per_len);
								if (period_sum >= target && edge_cnt[2:0] == 3'd0) begin
									run_st = ST_DONE;
									done   = 1'b1;
								end
							end
							if (!done) begin
								fall_stamp = stamp;
								edge_cnt   = edge_cnt + 1'b1;
							end
						end
						// no rising edge on this tick: run the disconnect timer
						if (!done) begin
							if (since_rise != '1)
								since_rise = since_rise + 1'b1;
							if (since_rise >= timeout_ticks)
								run_st = ST_NOCONN;
						end
					end
				end
			end
			expected_readings.push_back(result_t'{run_st, edge_cnt, period_sum, high_sum});
		endfunction

		function void field_check(string name, logic [SUM_BITS-1:0] want, logic [SUM_BITS-1:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// compare one result beat against the oldest prediction
		function void check_reading(result_t got);
			result_t want;
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected result beat, status %0d cycles %0d", $time,
					got.status, got.cycle_count);
				errors++;
				return;
			end
			want = expected_readings.pop_front();
			field_check("status", want.status, got.status);
			field_check("cycle_count", want.cycle_count, got.cycle_count);
			field_check("total_ticks", want.total_ticks, got.total_ticks);
			field_check("high_ticks", want.high_ticks, got.high_ticks);
		endfunction
	endclass

endpackage

// ===== test/pwm_duty_cycle_capture_tb.sv =====
// pwm_duty_cycle_capture_tb: drives pin samples and start beats with random gaps and stalls
// depends on pdc_pkg, pdc_tb_pkg and the pwm_duty_cycle_capture rtl
module pwm_duty_cycle_capture_tb;

	import pdc_pkg::*;
	import pdc_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AT        = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_BITS-1:0]  paddr;
	logic [DATA_BITS-1:0]  pwdata;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	logic                  kind;
	logic                  pin_level;
	logic [MS_BITS-1:0]    min_ms;
	logic                  out_valid;
	logic                  out_stall;
	logic [1:0]            status;
	logic [CNT_BITS-1:0]   cycle_count;
	logic [SUM_BITS-1:0]   total_ticks;
	logic [SUM_BITS-1:0]   high_ticks;

	duty_scoreboard board;
	int             beats_sent;
	int             readings_seen;
	bit             in_quiet;

	pwm_duty_cycle_capture u_dut (.*);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// one input beat, with a random gap in front
	task automatic send_beat(logic k, logic lvl, logic [MS_BITS-1:0] ms);
		int gap;
		if ($urandom_range(0, 39) == 0)
			in_quiet = !in_quiet;
		gap = (in_quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		pin_level <= lvl;
		min_ms    <= ms;
		do @(posedge clk); while (in_stall);
		board.note_sample(k, lvl, ms);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic tick(logic lvl);
		send_beat(KIND_TICK, lvl, MS_BITS'($urandom));
	endtask

	// pwm cycles of random high and low length
	task automatic pulse_train(int cycles, int hi_max, int lo_max);
		for (int c = 0; c < cycles; c++) begin
			repeat ($urandom_range(1, hi_max)) tick(1'b1);
			repeat ($urandom_range(1, lo_max)) tick(1'b0);
		end
	endtask

	// start plus a mostly well-formed pin sequence
	task automatic run_measurement(int ms_cap);
		int                 mode;
		logic               lvl;
		logic [MS_BITS-1:0] ms;
		ms = ($urandom_range(0, 9) == 0) ? MS_BITS'($urandom) : MS_BITS'($urandom_range(0, ms_cap));
		send_beat(KIND_START, 1'($urandom), ms);
		mode = $urandom_range(0, 9);
		if (mode <= 5) begin
			repeat ($urandom_range(0, 3)) tick(1'b0);
			pulse_train($urandom_range(8, 20), 4, 4);
		end else if (mode == 6) begin
			// restart in the middle of a measurement
			pulse_train($urandom_range(1, 10), 4, 4);
			send_beat(KIND_START, 1'($urandom), MS_BITS'($urandom_range(0, ms_cap)));
			pulse_train($urandom_range(8, 20), 4, 4);
		end else if (mode == 7) begin
			repeat ($urandom_range(5, 40)) tick(1'($urandom));
		end else if (mode == 8) begin
			// pin stuck at one level
			lvl = 1'($urandom);
			repeat ($urandom_range(1, 60)) tick(lvl);
		end else begin
			pulse_train($urandom_range(2, 9), 24, 24);
		end
	endtask

	// apb register write, setup then access
	task automatic cfg_write(logic idx, logic [DATA_BITS-1:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_TPM)
			board.ticks_per_ms = val[TPM_BITS-1:0];
		else
			board.timeout_ticks = val[TMO_BITS-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// wait for every predicted result, then let the pipeline settle
	task automatic drain(int extra);
		while (board.pending() != 0) @(posedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// result side: random stalls, one long hold to back up the input
	initial begin
		int gap;
		bit quiet;
		out_stall = 1'b0;
		quiet     = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				quiet = !quiet;
			gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 19);
			if (readings_seen == HOLD_AT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			board.check_reading(result_t'{status, cycle_count, total_ticks, high_ticks});
			readings_seen++;
			@(negedge clk);
		end
	end

	// watchdog on cycles without any accepted beat
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("pwm_duty_cycle_capture test failed");
		$finish;
	end

	// main sequence
	initial begin
		int tpm;
		int tmo;
		int budget;
		int ms_cap;
		int stop;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		kind          = KIND_TICK;
		pin_level     = 1'b0;
		min_ms        = '0;
		beats_sent    = 0;
		readings_seen = 0;
		in_quiet      = 1'b0;
		board         = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: edges while idle, wrong-direction edge, restart, finish, tick after finish
		tick(1'b0);
		tick(1'b1);
		send_beat(KIND_START, 1'b1, 16'hFFFF);
		tick(1'b0);
		send_beat(KIND_START, 1'b0, 16'h0000);
		pulse_train(9, 1, 1);
		tick(1'b1);
		in_valid <= 1'b0;
		drain(4);

		// random phases at several register settings
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					tpm    = 1;
					tmo    = 65536;
					budget = 420;
				end
				1: begin
					tpm    = 1000000;
					tmo    = 1;
					budget = 120;
				end
				2: begin
					tpm    = $urandom_range(1, 4);
					tmo    = $urandom_range(6, 30);
					budget = 420;
				end
				default: begin
					tpm    = $urandom_range(1, 1000000);
					tmo    = $urandom_range(1, 65536);
					budget = 360;
				end
			endcase
			ms_cap = 60 / tpm;
			cfg_write(REG_TPM, DATA_BITS'(tpm));
			cfg_write(REG_TMO, DATA_BITS'(tmo));
			stop = beats_sent + budget;
			// largest minimum time first, saturates the target at the top setting
			send_beat(KIND_START, 1'($urandom), 16'hFFFF);
			while (beats_sent < stop)
				run_measurement(ms_cap);
			in_valid <= 1'b0;
			drain(4);
		end

		drain(10);
		if (board.errors == 0)
			$display("pwm_duty_cycle_capture test passed");
		else
			$display("pwm_duty_cycle_capture test failed");
		$finish;
	end

endmodule

// ===== pwm_duty_cycle_capture.f =====
sv/pdc_pkg.sv
sv/pdc_regs.sv
sv/pdc_meas.sv
sv/pwm_duty_cycle_capture.sv
test/pdc_tb_pkg.sv
test/pwm_duty_cycle_capture_tb.sv
